// File: rtl/ider_pkg.sv
//------------------------------------------------------------------------------
// ider_pkg
// Shared types, constants and tables for the planar dead reckoning block.
//------------------------------------------------------------------------------
package ider_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int TAB_LEN      = 24;
    localparam int ITERS        = (CORDIC_ITERS > TAB_LEN) ? TAB_LEN : CORDIC_ITERS;
    localparam int IW           = (ITERS > 1) ? $clog2(ITERS) : 1;

    localparam int CW = 36;

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;
    localparam logic signed [CW-1:0] QUARTER      = 36'sh040000000;
    localparam logic signed [CW-1:0] HALF         = 36'sh080000000;
    localparam logic signed [CW-1:0] Q30_ONE      = 36'sh040000000;

    localparam logic signed [39:0] BANK_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] BANK_MIN = {1'b1, {39{1'b0}}};
    localparam logic signed [47:0] ACC_MAX  = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN  = {1'b1, {47{1'b0}}};

    typedef struct packed {
        logic               mode;
        logic signed [31:0] dist_step;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [15:0] yaw_angle;
        logic               pose_valid;
    } out_item_t;

    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:    r = 36'sh020000000;
            5'd1:    r = 36'sh012E4051E;
            5'd2:    r = 36'sh009FB385B;
            5'd3:    r = 36'sh0051111D4;
            5'd4:    r = 36'sh0028B0D43;
            5'd5:    r = 36'sh00145D7E1;
            5'd6:    r = 36'sh000A2F61E;
            5'd7:    r = 36'sh000517C55;
            5'd8:    r = 36'sh00028BE53;
            5'd9:    r = 36'sh000145F2F;
            5'd10:   r = 36'sh0000A2F98;
            5'd11:   r = 36'sh0000517CC;
            5'd12:   r = 36'sh000028BE6;
            5'd13:   r = 36'sh0000145F3;
            5'd14:   r = 36'sh00000A2F9;
            5'd15:   r = 36'sh00000517C;
            5'd16:   r = 36'sh0000028BE;
            5'd17:   r = 36'sh00000145F;
            5'd18:   r = 36'sh000000A2F;
            5'd19:   r = 36'sh000000517;
            5'd20:   r = 36'sh00000028B;
            5'd21:   r = 36'sh000000145;
            5'd22:   r = 36'sh0000000A2;
            5'd23:   r = 36'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ider_if.sv
//------------------------------------------------------------------------------
// ider_in_if / ider_out_if
// Valid/ready channels carrying input and result beats.
//------------------------------------------------------------------------------
interface ider_in_if import ider_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ider_out_if import ider_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ider_front.sv
//------------------------------------------------------------------------------
// ider_front
// Accepts beats and queues them (two entries) for the back end.
//------------------------------------------------------------------------------
module ider_front
    import ider_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ider_in_if.sink  in_ch,
    output logic     q_valid,
    input  logic     q_pop,
    output in_item_t q_data
);

    in_item_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_data      = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_ch.data;
    end

endmodule

// File: rtl/ider_cordic.sv
//------------------------------------------------------------------------------
// ider_cordic
// Shared iterative CORDIC: vectoring (atan2) or rotating (cos/sin).
//------------------------------------------------------------------------------
module ider_cordic
    import ider_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 vec_mode,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [IW-1:0]        i_reg;
    logic                 busy_reg, done_reg, vec_reg;
    logic                 dir;
    logic signed [CW-1:0] xs, ys, at;

    assign dir   = vec_reg ? (y_reg >= 0) : (z_reg >= 0);
    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign at    = atan_entry(5'(i_reg));
    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                vec_reg  <= vec_mode;
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= z_in;
            end
            else if (busy_reg)
            begin
                if (vec_reg == dir)
                begin
                    // vectoring y>=0 / rotating z<0 share this direction
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                end
                if (dir)
                    z_reg <= vec_reg ? z_reg + at : z_reg - at;
                else
                    z_reg <= vec_reg ? z_reg - at : z_reg + at;
                if (i_reg == IW'(ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    i_reg <= i_reg + 1'b1;
            end
        end
    end

endmodule

// File: rtl/ider_back.sv
//------------------------------------------------------------------------------
// ider_back
// Executes queued beats: banks distance, derives yaw, moves the position.
//------------------------------------------------------------------------------
module ider_back
    import ider_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  in_item_t  q_data,
    ider_out_if.source out_ch
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_SUM, S_VEC, S_HEAD, S_ROT, S_MUL, S_ACC, S_OUT
    } state_t;

    state_t               state_reg;
    logic signed [39:0]   bank_reg;
    logic signed [47:0]   acc_x_reg, acc_y_reg;
    logic signed [15:0]   yaw_reg;
    logic                 seen_imu_reg, seen_enc_reg;
    logic signed [31:0]   p_wz_reg, p_xy_reg, p_yy_reg, p_zz_reg, p_xz_reg, p_wy_reg;
    logic signed [CW-1:0] num_reg, den_reg;
    logic                 pole_reg;
    logic                 neg_reg;
    logic signed [15:0]   c_reg, s_reg;
    logic signed [56:0]   mx_reg, my_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 c_start, c_vec, c_done;
    logic signed [CW-1:0] c_xi, c_yi, c_zi, c_xo, c_yo, c_zo;

    logic signed [40:0]   bank_sum;
    logic signed [CW-1:0] g_val, vx, vy, vz;
    logic signed [15:0]   yaw_new, head;
    logic signed [CW-1:0] hz, hz_adj;
    logic                 h_neg;
    logic signed [15:0]   cq, sq;
    logic signed [48:0]   ax_sum, ay_sum;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v,
                                                  input logic neg);
        logic signed [CW-1:0] r;
        r = (v + CW'(16384)) >>> 15;
        if (neg)
            r = -r;
        if (r > CW'(32767))
            return 16'sd32767;
        else if (r < -CW'(32768))
            return -16'sd32768;
        else
            return r[15:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v > 49'(ACC_MAX))
            return ACC_MAX;
        else if (v < 49'(ACC_MIN))
            return ACC_MIN;
        else
            return v[47:0];
    endfunction

    ider_cordic u_cordic (
        .clk, .rst_n, .start(c_start), .vec_mode(c_vec),
        .x_in(c_xi), .y_in(c_yi), .z_in(c_zi),
        .done(c_done), .x_out(c_xo), .y_out(c_yo), .z_out(c_zo)
    );

    assign q_pop        = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    assign bank_sum = {bank_reg[39], bank_reg} + 41'(q_data.dist_step);
    assign g_val    = CW'(p_xz_reg) - CW'(p_wy_reg);

    always_comb
    begin
        vx = den_reg;
        vy = num_reg;
        vz = '0;
        if (den_reg < 0)
        begin
            if (num_reg >= 0)
            begin
                vx = num_reg;
                vy = -den_reg;
                vz = QUARTER;
            end
            else
            begin
                vx = -num_reg;
                vy = den_reg;
                vz = -QUARTER;
            end
        end
    end

    assign yaw_new = 16'((c_zo + CW'(32768)) >>> 16);
    assign head    = -yaw_reg;
    assign hz      = {{(CW-32){head[15]}}, head, 16'h0000};
    always_comb
    begin
        hz_adj = hz;
        h_neg  = 1'b0;
        if (hz > QUARTER)
        begin
            hz_adj = hz - HALF;
            h_neg  = 1'b1;
        end
        else if (hz < -QUARTER)
        begin
            hz_adj = hz + HALF;
            h_neg  = 1'b1;
        end
    end

    assign cq     = to_q15(c_xo, neg_reg);
    assign sq     = to_q15(c_yo, neg_reg);
    assign ax_sum = {acc_x_reg[47], acc_x_reg} + 49'((mx_reg + 57'sd16384) >>> 15);
    assign ay_sum = {acc_y_reg[47], acc_y_reg} + 49'((my_reg + 57'sd16384) >>> 15);

    always_comb
    begin
        c_start = 1'b0;
        c_vec   = 1'b1;
        c_xi    = vx;
        c_yi    = vy;
        c_zi    = vz;
        case (state_reg)
            S_SUM:
            begin
                c_start = !pole_reg && !(num_reg == 0 && den_reg == 0);
            end
            S_HEAD:
            begin
                c_start = 1'b1;
                c_vec   = 1'b0;
                c_xi    = INV_GAIN_Q30;
                c_yi    = '0;
                c_zi    = hz_adj;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            yaw_reg       <= '0;
            seen_imu_reg  <= 1'b0;
            seen_enc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (!q_data.mode)
                        begin
                            if (bank_sum > 41'(BANK_MAX))
                                bank_reg <= BANK_MAX;
                            else if (bank_sum < 41'(BANK_MIN))
                                bank_reg <= BANK_MIN;
                            else
                                bank_reg <= bank_sum[39:0];
                            seen_enc_reg <= 1'b1;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            p_wz_reg  <= q_data.quat_w * q_data.quat_z;
                            p_xy_reg  <= q_data.quat_x * q_data.quat_y;
                            p_yy_reg  <= q_data.quat_y * q_data.quat_y;
                            p_zz_reg  <= q_data.quat_z * q_data.quat_z;
                            p_xz_reg  <= q_data.quat_x * q_data.quat_z;
                            p_wy_reg  <= q_data.quat_w * q_data.quat_y;
                            state_reg <= S_PROD;
                        end
                    end
                end
                S_PROD:
                begin
                    num_reg   <= (CW'(p_wz_reg) + CW'(p_xy_reg)) <<< 1;
                    den_reg   <= Q30_ONE - ((CW'(p_yy_reg) + CW'(p_zz_reg)) <<< 1);
                    pole_reg  <= ((g_val <<< 1) >= Q30_ONE) || ((g_val <<< 1) <= -Q30_ONE);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (c_start)
                        state_reg <= S_VEC;
                    else
                    begin
                        yaw_reg   <= '0;
                        state_reg <= S_HEAD;
                    end
                end
                S_VEC:
                begin
                    if (c_done)
                    begin
                        yaw_reg   <= yaw_new;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    neg_reg   <= h_neg;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (c_done)
                    begin
                        c_reg     <= cq;
                        s_reg     <= sq;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mx_reg    <= 57'(c_reg) * 57'(bank_reg);
                    my_reg    <= 57'(s_reg) * 57'(bank_reg);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_x_reg    <= sat48(ax_sum);
                    acc_y_reg    <= sat48(ay_sum);
                    bank_reg     <= '0;
                    seen_imu_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg       <= 1'b1;
                    out_reg.pos_x      <= acc_x_reg;
                    out_reg.pos_y      <= acc_y_reg;
                    out_reg.yaw_angle  <= yaw_reg;
                    out_reg.pose_valid <= seen_imu_reg && seen_enc_reg;
                    state_reg          <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/imu_encoder_dead_reckoning.sv
//------------------------------------------------------------------------------
// imu_encoder_dead_reckoning
// Planar dead reckoning from encoder increments and orientation quaternions.
//------------------------------------------------------------------------------
// Channels: in_ch (sink) takes one beat per item, mode 0 = distance step,
// mode 1 = quaternion; out_ch (source) gives one pose beat per item.
// A two-entry queue parts the accepting front from the executing back end,
// so beats are taken while a pose waits on out_ch.
// An encoder beat banks its distance and goes straight to the pose; an
// orientation beat runs the shared iterative CORDIC through a vectoring then a
// rotating pass (the vectoring pass is skipped at the pole or a zero vector)
// before the pose. The back end pops the next beat only after the pose is
// taken, so it works on one item at a time.
// Reset clears the bank, position, yaw and seen flags; the queue empties.
// When out_ch stalls the back end holds the pose and stops popping; the
// queue then fills and in_ch.ready drops.
//------------------------------------------------------------------------------
module imu_encoder_dead_reckoning
    import ider_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ider_in_if.sink    in_ch,
    ider_out_if.source out_ch
);

    logic     q_valid, q_pop;
    in_item_t q_data;

    ider_front u_front (
        .clk, .rst_n, .in_ch, .q_valid, .q_pop, .q_data
    );

    ider_back u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_data, .out_ch
    );

endmodule
